### design/lkc_pkg.sv
// Package: sizes, codes and item types for the LRU key cache directory.
`default_nettype none

package lkc_pkg;

	// Directory size and compared key bits
	localparam int WAYS         = 16;
	localparam int KEY_BITS     = 16;

	// Fixed field widths of the item ports
	localparam int KEY_W        = 16;
	localparam int CAP_W        = 5;
	localparam int COUNT_W      = 5;

	// Derived widths
	localparam int KEY_CMP_BITS = (KEY_BITS < KEY_W) ? KEY_BITS : KEY_W;
	localparam int WAY_BITS     = $clog2(WAYS);
	localparam int RANK_BITS    = $clog2(WAYS);
	localparam int CNT_BITS     = $clog2(WAYS + 1);

	localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

	typedef logic [KEY_CMP_BITS-1:0] tag_t;
	typedef logic [RANK_BITS-1:0]    rank_t;
	typedef logic [WAY_BITS-1:0]     way_t;
	typedef logic [CNT_BITS-1:0]     cnt_t;

	typedef enum logic {
		ACT_ACCESS = 1'b0,
		ACT_CLEAR  = 1'b1
	} action_t;

	typedef enum logic [1:0] {
		ST_HIT   = 2'd0,
		ST_FILL  = 2'd1,
		ST_MISS  = 2'd2,
		ST_CLEAR = 2'd3
	} status_t;

	typedef struct packed {
		action_t          action;
		logic [KEY_W-1:0] key;
		logic             load_ok;
	} req_t;

	typedef struct packed {
		status_t            status;
		logic               evicted;
		logic [KEY_W-1:0]   evicted_key;
		logic [COUNT_W-1:0] entries_in_use;
	} rsp_t;

endpackage

`default_nettype wire

### design/lru_key_cache_policy.sv
// Top level: fully associative LRU key directory with one result per item.
// Items pass through the input register, then the result register; all WAYS tags are compared
// and all ranks updated together. Throughput: one item per cycle unless out_ready stalls.
// The next item sees the directory as left by the previous one, so items never wait on each other.
// Reset (arst_n low): directory empty, all ranks zero, capacity 16, both stages empty.
`default_nettype none

module lru_key_cache_policy
	import lkc_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_ready,
	input  wire req_t             in_item,
	output logic                  out_valid,
	input  wire logic             out_ready,
	output rsp_t                  out_item,
	input  wire logic             cfg_we,
	input  wire logic [CAP_W-1:0] cfg_wdata
);

	logic [CAP_W-1:0] capacity_q;

	// Input stage
	logic valid_s1;
	req_t item_s1;

	// Directory state
	logic  [WAYS-1:0] entry_valid_q;
	tag_t             entry_key_q  [WAYS];
	rank_t            rank_q       [WAYS];
	cnt_t             count_q;

	// Result stage
	logic out_valid_q;
	rsp_t out_item_q;

	logic advance;

	// Next directory state and result
	logic  [WAYS-1:0] valid_d;
	rank_t            rank_d  [WAYS];
	cnt_t             count_d;
	rsp_t             rsp_d;
	logic             key_we;
	way_t             key_wa;

	tag_t             req_tag;
	logic             hit_any;
	way_t             hit_idx;
	logic             vic_any;
	way_t             vic_idx;
	logic             free_any;
	way_t             free_idx;
	logic [31:0]      cap_eff;
	logic             full;
	logic             do_evict;
	logic             slot_any;
	way_t             slot_idx;

	assign advance   = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready  = !valid_s1 || advance;
	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;

	// Hold the capacity register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= CAP_RESET;
		end else if (cfg_we) begin
			capacity_q <= cfg_wdata;
		end
	end

	// Track input stage occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	// Capture the incoming item
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= in_item;
		end
	end

	// Look up, pick the slot and build the next directory state
	always_comb begin
		req_tag  = item_s1.key[KEY_CMP_BITS-1:0];
		hit_any  = 1'b0;
		hit_idx  = '0;
		vic_any  = 1'b0;
		vic_idx  = '0;
		free_any = 1'b0;
		free_idx = '0;

		// Lowest-numbered match, victim and free entry
		for (int i = 0; i < WAYS; i++) begin
			if (!hit_any && entry_valid_q[i] && entry_key_q[i] == req_tag) begin
				hit_any = 1'b1;
				hit_idx = WAY_BITS'(i);
			end
			// Valid ranks are distinct 0..count-1, so the oldest holds count-1
			if (!vic_any && entry_valid_q[i] &&
			    32'(rank_q[i]) == 32'(count_q) - 32'd1) begin
				vic_any = 1'b1;
				vic_idx = WAY_BITS'(i);
			end
			if (!free_any && !entry_valid_q[i]) begin
				free_any = 1'b1;
				free_idx = WAY_BITS'(i);
			end
		end

		// Clamp the capacity to 1..WAYS
		cap_eff = 32'(capacity_q);
		if (cap_eff == 32'd0) begin
			cap_eff = 32'd1;
		end
		if (cap_eff > 32'(WAYS)) begin
			cap_eff = 32'(WAYS);
		end
		full     = 32'(count_q) >= cap_eff;
		do_evict = full && vic_any;
		slot_any = do_evict || free_any;
		slot_idx = do_evict ? vic_idx : free_idx;

		valid_d = entry_valid_q;
		count_d = count_q;
		key_we  = 1'b0;
		key_wa  = slot_idx;
		for (int i = 0; i < WAYS; i++) begin
			rank_d[i] = rank_q[i];
		end
		rsp_d.status      = ST_HIT;
		rsp_d.evicted     = 1'b0;
		rsp_d.evicted_key = '0;

		case (item_s1.action)
			ACT_CLEAR: begin
				valid_d = '0;
				count_d = '0;
				for (int i = 0; i < WAYS; i++) begin
					rank_d[i] = '0;
				end
				rsp_d.status = ST_CLEAR;
			end
			ACT_ACCESS: begin
				if (hit_any) begin
					// Promote the hit entry, age the ones that were newer
					for (int i = 0; i < WAYS; i++) begin
						if (WAY_BITS'(i) == hit_idx) begin
							rank_d[i] = '0;
						end else if (entry_valid_q[i] && rank_q[i] < rank_q[hit_idx]) begin
							rank_d[i] = rank_q[i] + rank_t'(1);
						end
					end
					rsp_d.status = ST_HIT;
				end else if (!item_s1.load_ok) begin
					rsp_d.status = ST_MISS;
				end else begin
					rsp_d.status = ST_FILL;
					if (do_evict) begin
						rsp_d.evicted     = 1'b1;
						rsp_d.evicted_key = KEY_W'(entry_key_q[vic_idx]);
					end
					if (slot_any) begin
						key_we = 1'b1;
						// New entry is the newest; every other valid entry ages
						for (int i = 0; i < WAYS; i++) begin
							if (WAY_BITS'(i) == slot_idx) begin
								rank_d[i]  = '0;
								valid_d[i] = 1'b1;
							end else if (entry_valid_q[i]) begin
								rank_d[i] = rank_q[i] + rank_t'(1);
							end
						end
						if (!do_evict) begin
							count_d = count_q + cnt_t'(1);
						end
					end
				end
			end
			default: begin
				rsp_d.status = ST_MISS;
			end
		endcase

		rsp_d.entries_in_use = COUNT_W'(count_d);
	end

	// Update directory control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_valid_q <= '0;
			count_q       <= '0;
			for (int i = 0; i < WAYS; i++) begin
				rank_q[i] <= '0;
			end
		end else if (advance) begin
			entry_valid_q <= valid_d;
			count_q       <= count_d;
			for (int i = 0; i < WAYS; i++) begin
				rank_q[i] <= rank_d[i];
			end
		end
	end

	// Write the filled key
	always_ff @(posedge clk) begin
		if (advance && key_we) begin
			entry_key_q[key_wa] <= req_tag;
		end
	end

	// Hold the result until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_item_q <= rsp_d;
		end
	end

endmodule

`default_nettype wire

### test/tb.sv
// Testbench for the LRU key cache directory: random and directed items checked against a predictor.
`timescale 1ns / 1ps

module tb;
	import lkc_pkg::*;

	logic               clk       = 1'b0;
	logic               arst_n    = 1'b0;
	logic               in_valid  = 1'b0;
	logic               in_ready;
	req_t               in_item   = '0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	rsp_t               out_item;
	logic               cfg_we    = 1'b0;
	logic [CAP_W-1:0]   cfg_wdata = CAP_RESET;

	lru_key_cache_policy i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_item   (in_item),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	// Directory mirror: valid bits, tags, recency ranks (0 = most recent), count, capacity
	logic             dir_valid [WAYS];
	tag_t             dir_tag   [WAYS];
	int unsigned      dir_rank  [WAYS];
	int unsigned      dir_count    = 0;
	logic [CAP_W-1:0] capacity_reg = CAP_RESET;

	req_t queued_lookups    [$];
	rsp_t predicted_results [$];

	int send_idle_pct  = 0;
	int recv_stall_pct = 0;
	int hold_req       = 0;
	int hold_seen      = 0;
	int hold_left      = 0;

	int items_accepted = 0;
	int results_seen   = 0;
	int mismatches     = 0;
	int status_count [4];
	int evictions      = 0;

	// Per-phase capacity, sender idle, receiver stall and long hold-off
	int phase_cap   [8] = '{16, 1, 0, 31, 4, 17, 3, 8};
	int phase_idle  [8] = '{0, 56, 0, 29, 0, 56, 0, 29};
	int phase_stall [8] = '{0, 0, 56, 29, 0, 0, 56, 29};
	int phase_hold  [8] = '{0, 0, 0, 1, 0, 0, 0, 1};

	localparam int PHASE_ITEMS = 205;
	localparam int HOLD_CYCLES = 80;

	initial begin
		for (int i = 0; i < WAYS; i++) begin
			dir_valid[i] = 1'b0;
			dir_tag[i]   = '0;
			dir_rank[i]  = 0;
		end
		for (int i = 0; i < 4; i++)
			status_count[i] = 0;
	end

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Move way w to the front; every valid way more recent than old_rank moves back by one
	function automatic void make_most_recent(int w, int unsigned old_rank);
		for (int i = 0; i < WAYS; i++)
			if (i != w && dir_valid[i] && dir_rank[i] < old_rank)
				dir_rank[i]++;
		dir_rank[w] = 0;
	endfunction

	// Apply one item to the mirror and return the result it should produce
	function automatic rsp_t predict_lookup(req_t req);
		rsp_t        r;
		int          hit;
		int          slot;
		int unsigned best;
		int unsigned eff_cap;
		r = '0;
		if (req.action == ACT_CLEAR) begin
			for (int i = 0; i < WAYS; i++) begin
				dir_valid[i] = 1'b0;
				dir_rank[i]  = 0;
			end
			dir_count = 0;
			r.status  = ST_CLEAR;
		end else begin
			hit = -1;
			for (int i = 0; i < WAYS; i++)
				if (hit < 0 && dir_valid[i] && dir_tag[i] == tag_t'(req.key))
					hit = i;
			if (hit >= 0) begin
				make_most_recent(hit, dir_rank[hit]);
				r.status = ST_HIT;
			end else if (!req.load_ok) begin
				r.status = ST_MISS;
			end else begin
				slot    = -1;
				eff_cap = (capacity_reg == 0) ? 1 : int'(capacity_reg);
				if (eff_cap > WAYS)
					eff_cap = WAYS;
				// Evict the oldest way; lowest index wins a tie
				if (dir_count >= eff_cap) begin
					best = 0;
					for (int i = 0; i < WAYS; i++)
						if (dir_valid[i] && (slot < 0 || dir_rank[i] > best)) begin
							slot = i;
							best = dir_rank[i];
						end
					if (slot >= 0) begin
						r.evicted     = 1'b1;
						r.evicted_key = KEY_W'(dir_tag[slot]);
						dir_valid[slot] = 1'b0;
						dir_count--;
					end
				end
				if (slot < 0)
					for (int i = WAYS - 1; i >= 0; i--)
						if (!dir_valid[i])
							slot = i;
				if (slot >= 0) begin
					make_most_recent(slot, 32'hFFFF_FFFF);
					dir_valid[slot] = 1'b1;
					dir_tag[slot]   = tag_t'(req.key);
					dir_count++;
				end
				r.status = ST_FILL;
			end
		end
		r.entries_in_use = COUNT_W'(dir_count);
		return r;
	endfunction

	function automatic req_t make_req(action_t act, logic [KEY_W-1:0] key, logic load_ok);
		req_t r;
		r.action  = act;
		r.key     = key;
		r.load_ok = load_ok;
		return r;
	endfunction

	// Mostly keys from a small pool so hits and evictions are frequent
	function automatic req_t random_access(int unsigned pool_base, int unsigned pool_size);
		req_t        r;
		int unsigned pick;
		r.action = ($urandom_range(99) < 3) ? ACT_CLEAR : ACT_ACCESS;
		pick = $urandom_range(99);
		if (pick < 70)
			r.key = KEY_W'(pool_base + $urandom_range(pool_size - 1));
		else if (pick < 88)
			r.key = KEY_W'($urandom);
		else
			r.key = pick[0] ? '1 : '0;
		r.load_ok = ($urandom_range(99) < 80);
		return r;
	endfunction

	// Drive the input channel: hold an item until accepted, then offer the next one
	always @(posedge clk) begin
		rsp_t want;
		if (arst_n) begin
			if (in_valid && in_ready) begin
				want = predict_lookup(in_item);
				predicted_results.push_back(want);
				items_accepted++;
				status_count[want.status]++;
				if (want.evicted)
					evictions++;
			end
			if (!in_valid || in_ready) begin
				if (queued_lookups.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					in_item  <= queued_lookups.pop_front();
					in_valid <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Drive out_ready: random stalls, or a long hold-off when one is requested
	always @(posedge clk) begin
		if (arst_n) begin
			if (hold_req != hold_seen) begin
				hold_seen <= hold_req;
				hold_left <= HOLD_CYCLES;
				out_ready <= 1'b0;
			end else if (hold_left > 0) begin
				hold_left <= hold_left - 1;
				out_ready <= 1'b0;
			end else begin
				out_ready <= ($urandom_range(99) >= recv_stall_pct);
			end
		end
	end

	// Check each result against the oldest prediction
	always @(posedge clk) begin
		rsp_t want;
		if (arst_n && out_valid && out_ready) begin
			results_seen++;
			if (predicted_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: unexpected result status=%0d ev=%0b ev_key=%h count=%0d",
						$realtime, out_item.status, out_item.evicted,
						out_item.evicted_key, out_item.entries_in_use);
			end else begin
				want = predicted_results.pop_front();
				if (out_item.status != want.status || out_item.evicted != want.evicted ||
				    out_item.evicted_key != want.evicted_key ||
				    out_item.entries_in_use != want.entries_in_use) begin
					mismatches++;
					if (mismatches <= 10)
						$display("%0t: result %0d exp st=%0d ev=%0b key=%h cnt=%0d, got st=%0d ev=%0b key=%h cnt=%0d",
							$realtime, results_seen, want.status, want.evicted,
							want.evicted_key, want.entries_in_use, out_item.status,
							out_item.evicted, out_item.evicted_key, out_item.entries_in_use);
				end
			end
		end
	end

	task automatic wait_idle();
		while (queued_lookups.size() != 0 || in_valid || predicted_results.size() != 0)
			@(negedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_capacity(logic [CAP_W-1:0] value);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we    <= 1'b0;
		capacity_reg = value;
	endtask

	// Stimulus: reset, directed items, then the random phases
	initial begin
		int unsigned pool_base;
		int unsigned pool_size;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Clear on empty ignores key and load_ok; then miss, fill, hit at the key extremes
		queued_lookups.push_back(make_req(ACT_CLEAR, '1, 1'b1));
		queued_lookups.push_back(make_req(ACT_ACCESS, '0, 1'b0));
		queued_lookups.push_back(make_req(ACT_ACCESS, '0, 1'b1));
		queued_lookups.push_back(make_req(ACT_ACCESS, '0, 1'b0));
		queued_lookups.push_back(make_req(ACT_ACCESS, '1, 1'b1));
		queued_lookups.push_back(make_req(ACT_ACCESS, '1, 1'b0));
		// Fill to full capacity, then one more fill evicts the oldest way
		for (int i = 1; i <= 14; i++)
			queued_lookups.push_back(make_req(ACT_ACCESS, KEY_W'(i), 1'b1));
		queued_lookups.push_back(make_req(ACT_ACCESS, 16'h8000, 1'b1));
		queued_lookups.push_back(make_req(ACT_CLEAR, '0, 1'b0));
		wait_idle();

		for (int p = 0; p < 8; p++) begin
			write_capacity(CAP_W'(phase_cap[p]));
			@(negedge clk);
			send_idle_pct  = phase_idle[p];
			recv_stall_pct = phase_stall[p];
			pool_size = (phase_cap[p] == 0) ? 1 : phase_cap[p];
			if (pool_size > WAYS)
				pool_size = WAYS;
			pool_size = pool_size + 3;
			pool_base = $urandom_range(16'hFFF0);
			for (int i = 0; i < PHASE_ITEMS; i++)
				queued_lookups.push_back(random_access(pool_base, pool_size));
			// Leave the directory full so the next, lower capacity sits below the count
			if (phase_cap[p + 1 < 8 ? p + 1 : p] < phase_cap[p] && phase_cap[p] > 8)
				for (int i = 0; i < WAYS; i++)
					queued_lookups.push_back(make_req(ACT_ACCESS, KEY_W'(16'h0100 + i), 1'b1));
			if (phase_hold[p] != 0)
				hold_req++;
			wait_idle();
		end

		repeat (10) @(posedge clk);
		if (predicted_results.size() != 0)
			mismatches++;
		$display("Ran %0d items, %0d results, 8 capacity settings incl. 0, 1 and 31.",
			items_accepted, results_seen);
		$display("Hits %0d, fills %0d, load failures %0d, clears %0d, evictions %0d.",
			status_count[ST_HIT], status_count[ST_FILL], status_count[ST_MISS],
			status_count[ST_CLEAR], evictions);
		if (mismatches == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

	// Watchdog
	initial begin
		#(2_000_000);
		$display("FAIL");
		$finish;
	end

endmodule

### files.f
design/lkc_pkg.sv
design/lru_key_cache_policy.sv
test/tb.sv
